// ===== sv/spbp_pkg.sv =====
// ----------------------------------------------------------------------------
// spbp_pkg
// Shared widths, register indexes, reset values and defaults for the
// superpacket burst packer.
// ----------------------------------------------------------------------------
package spbp_pkg;

    // Field widths
    localparam int LEN_W     = 14;
    localparam int BUF_W     = 10;
    localparam int OFF_W     = 16;
    localparam int CNT_W     = 8;
    localparam int BURST_W   = 11;
    localparam int TOTAL_W   = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Slot alignment (bytes, as a power of two)
    localparam int ALIGN_LOG2 = 3;

    // Saturation value of the running payload total
    localparam logic [TOTAL_W-1:0] PAYLOAD_MAX = '1;

    // Default header and minimum packet sizes
    localparam int HDR_BYTES_DEF = 16;
    localparam int MIN_BYTES_DEF = 60;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SUPER_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HDR_REGULAR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SP_BYTES    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SP_MAX_CNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BURST_LIMIT = 3'd4;

    // Configuration reset values
    localparam logic                 RST_SUPER_MODE  = 1'b0;
    localparam logic                 RST_HDR_REGULAR = 1'b1;
    localparam logic [OFF_W-1:0]     RST_SP_BYTES    = 16'd8192;
    localparam logic [CNT_W-1:0]     RST_SP_MAX_CNT  = 8'd64;
    localparam logic [BURST_W-1:0]   RST_BURST_LIMIT = 11'd64;

endpackage

// ===== sv/superpacket_burst_packer_unit.sv =====
// Path: input transaction into the input register, then the result into the result register.
// Throughput: one transaction per cycle while i_stall does not hold the result; the
// packing decision is combinational adds and compares plus a state update after the input register.
// Reset (i_rst_n low, synchronous): burst state cleared, pipeline emptied,
// configuration registers loaded with their default values.
// ----------------------------------------------------------------------------
// superpacket_burst_packer_unit
// Pads each packet length to a minimum size and assigns it a buffer slot by next-fit
// superpacket packing or one buffer per packet, or rejects it past the burst limit.
// ----------------------------------------------------------------------------
module superpacket_burst_packer_unit
    import spbp_pkg::*;
#(
    parameter int HDR_BYTES = HDR_BYTES_DEF,
    parameter int MIN_BYTES = MIN_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,

    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [LEN_W-1:0]     i_packet_len,
    input  logic                 i_burst_end,

    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [BUF_W-1:0]     o_buffer_index,
    output logic [OFF_W-1:0]     o_header_offset,
    output logic [OFF_W-1:0]     o_data_offset,
    output logic [LEN_W-1:0]     o_padded_len,
    output logic [LEN_W-1:0]     o_pad_len,
    output logic                 o_upscaled,
    output logic [TOTAL_W-1:0]   o_burst_payload_bytes,
    output logic                 o_rejected
);

    localparam int SLOT_MAX = (1 << LEN_W) - 1 + HDR_BYTES + (1 << ALIGN_LOG2) - 1;
    localparam int SLOT_W   = $clog2(SLOT_MAX + 1);
    localparam int FSUM_W   = ((SLOT_W > OFF_W) ? SLOT_W : OFF_W) + 1;

    localparam logic [LEN_W-1:0]  MIN_LEN   = LEN_W'(MIN_BYTES);
    localparam logic [OFF_W-1:0]  HDR_OFF   = OFF_W'(HDR_BYTES);
    localparam logic [SLOT_W-1:0] HDR_SLOT  = SLOT_W'(HDR_BYTES);
    localparam logic [SLOT_W-1:0] ALIGN_ADD = SLOT_W'((1 << ALIGN_LOG2) - 1);

    // Configuration registers
    logic               r_super_mode;
    logic               r_hdr_regular;
    logic [OFF_W-1:0]   r_sp_bytes;
    logic [CNT_W-1:0]   r_sp_max_cnt;
    logic [BURST_W-1:0] r_burst_limit;

    // Burst state
    logic [BUF_W-1:0]   r_cur_buf,   n_cur_buf;
    logic [OFF_W-1:0]   r_fill,      n_fill;
    logic [CNT_W-1:0]   r_cnt,       n_cnt;
    logic [BURST_W-1:0] r_pkts,      n_pkts;
    logic [TOTAL_W-1:0] r_total,     n_total;

    // Input register
    logic               r_s1_valid;
    logic [LEN_W-1:0]   r_s1_len;
    logic               r_s1_last;

    // Result register
    logic               r_out_valid;
    logic [BUF_W-1:0]   r_buf,   n_buf;
    logic [OFF_W-1:0]   r_hoff,  n_hoff;
    logic [OFF_W-1:0]   r_doff,  n_doff;
    logic [LEN_W-1:0]   r_padded, n_padded;
    logic [LEN_W-1:0]   r_pad,   n_pad;
    logic               r_up,    n_up;
    logic [TOTAL_W-1:0] r_tot_o, n_tot_o;
    logic               r_rej,   n_rej;

    logic in_fire;
    logic s1_fire;
    logic out_free;

    logic                c_up;
    logic [LEN_W-1:0]    c_padded;
    logic [TOTAL_W:0]    c_sum;
    logic [TOTAL_W-1:0]  c_total;
    logic [SLOT_W-1:0]   c_slot_raw;
    logic [SLOT_W-1:0]   c_slot;
    logic [FSUM_W-1:0]   c_fill_sum;
    logic                c_fits;
    logic [OFF_W-1:0]    c_hoff;

    // Handshake
    assign out_free = !r_out_valid || !i_stall;
    assign s1_fire  = r_s1_valid && out_free;
    assign o_stall  = r_s1_valid && !out_free;
    assign in_fire  = i_valid && !o_stall;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_super_mode  <= RST_SUPER_MODE;
            r_hdr_regular <= RST_HDR_REGULAR;
            r_sp_bytes    <= RST_SP_BYTES;
            r_sp_max_cnt  <= RST_SP_MAX_CNT;
            r_burst_limit <= RST_BURST_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SUPER_MODE:  r_super_mode  <= i_cfg_data[0];
                REG_HDR_REGULAR: r_hdr_regular <= i_cfg_data[0];
                REG_SP_BYTES:    r_sp_bytes    <= i_cfg_data[OFF_W-1:0];
                REG_SP_MAX_CNT:  r_sp_max_cnt  <= i_cfg_data[CNT_W-1:0];
                REG_BURST_LIMIT: r_burst_limit <= i_cfg_data[BURST_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_len  <= i_packet_len;
            r_s1_last <= i_burst_end;
        end
    end

    // Pad, size the slot and test the fit
    always_comb begin
        c_up       = r_s1_len < MIN_LEN;
        c_padded   = c_up ? MIN_LEN : r_s1_len;
        c_sum      = {1'b0, r_total} + (TOTAL_W + 1)'(c_padded);
        c_total    = c_sum[TOTAL_W] ? PAYLOAD_MAX : c_sum[TOTAL_W-1:0];
        c_slot_raw = HDR_SLOT + SLOT_W'(c_padded) + ALIGN_ADD;
        c_slot     = {c_slot_raw[SLOT_W-1:ALIGN_LOG2], {ALIGN_LOG2{1'b0}}};
        c_fill_sum = FSUM_W'(r_fill) + FSUM_W'(c_slot);
        c_fits     = (c_fill_sum <= FSUM_W'(r_sp_bytes)) && (r_cnt < r_sp_max_cnt);
        c_hoff     = c_fits ? r_fill : '0;
    end

    // Form the result and the next burst state
    always_comb begin
        n_cur_buf = r_cur_buf;
        n_fill    = r_fill;
        n_cnt     = r_cnt;
        n_pkts    = r_pkts;
        n_total   = r_total;

        n_buf    = '0;
        n_hoff   = '0;
        n_doff   = '0;
        n_padded = '0;
        n_pad    = '0;
        n_up     = 1'b0;
        n_rej    = 1'b0;

        if (r_pkts >= r_burst_limit) begin
            n_rej = 1'b1;
        end else begin
            n_padded = c_padded;
            n_pad    = c_padded - r_s1_len;
            n_up     = c_up;
            n_total  = c_total;
            n_pkts   = r_pkts + 1'b1;
            if (r_super_mode) begin
                if (c_fits) begin
                    n_fill = c_fill_sum[OFF_W-1:0];
                    n_cnt  = r_cnt + 1'b1;
                end else begin
                    if (r_cnt != '0) begin
                        n_cur_buf = r_cur_buf + 1'b1;
                    end
                    n_fill = OFF_W'(c_slot);
                    n_cnt  = CNT_W'(1);
                end
                n_buf  = n_cur_buf;
                n_hoff = c_hoff;
                n_doff = c_hoff + HDR_OFF;
            end else begin
                n_buf  = r_pkts[BUF_W-1:0];
                n_doff = r_hdr_regular ? HDR_OFF : '0;
            end
        end
        n_tot_o = n_total;

        // Drop all burst state after the last packet
        if (r_s1_last) begin
            n_cur_buf = '0;
            n_fill    = '0;
            n_cnt     = '0;
            n_pkts    = '0;
            n_total   = '0;
        end
    end

    // Advance burst state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_buf <= '0;
            r_fill    <= '0;
            r_cnt     <= '0;
            r_pkts    <= '0;
            r_total   <= '0;
        end else if (s1_fire) begin
            r_cur_buf <= n_cur_buf;
            r_fill    <= n_fill;
            r_cnt     <= n_cnt;
            r_pkts    <= n_pkts;
            r_total   <= n_total;
        end
    end

    // Hold the result until the consumer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_buf    <= n_buf;
            r_hoff   <= n_hoff;
            r_doff   <= n_doff;
            r_padded <= n_padded;
            r_pad    <= n_pad;
            r_up     <= n_up;
            r_tot_o  <= n_tot_o;
            r_rej    <= n_rej;
        end
    end

    assign o_valid               = r_out_valid;
    assign o_buffer_index        = r_buf;
    assign o_header_offset       = r_hoff;
    assign o_data_offset         = r_doff;
    assign o_padded_len          = r_padded;
    assign o_pad_len             = r_pad;
    assign o_upscaled            = r_up;
    assign o_burst_payload_bytes = r_tot_o;
    assign o_rejected            = r_rej;

`ifndef SYNTH
    // Burst state is empty after the last packet of a burst leaves the input register
    a_burst_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_last) |=>
            (r_pkts == '0 && r_total == '0 && r_fill == '0 && r_cnt == '0 && r_cur_buf == '0))
        else $error("burst state not cleared after last packet");

    // A rejected result carries no slot information
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rejected) |->
            (o_buffer_index == '0 && o_padded_len == '0 && o_header_offset == '0))
        else $error("rejected result carries slot fields");

    // A packed packet in superpacket mode leaves a non-empty superpacket
    a_super_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_super_mode && !n_rej && !r_s1_last) |=> (r_cnt != '0))
        else $error("superpacket count empty after packing");
`endif

endmodule
